// ===== sv/ilc_pkg.sv =====
package ilc_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned PosW     = 5;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW + 1 : PosW + 1;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned LengthW  = 16;
  localparam int unsigned OutCntW  = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SELECT = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4,
    OP_READ   = 3'd5
  } opcode_e;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [LengthW-1:0] length;
  } entry_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdxW-1:0] pos_idx;
    entry_t          data;
  } cell_cmd_t;

endpackage

// ===== sv/ilc_if.sv =====
interface ilc_in_if;
  import ilc_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [PosW-1:0]    position;
  logic [HandleW-1:0] record_handle;
  logic [LengthW-1:0] record_length;

  modport source (output valid, opcode, position, record_handle, record_length,
                  input ready);
  modport sink   (input valid, opcode, position, record_handle, record_length,
                  output ready);
endinterface

interface ilc_out_if;
  import ilc_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [HandleW-1:0] out_handle;
  logic [LengthW-1:0] out_length;
  logic               read_is_current;
  logic [OutCntW-1:0] entry_count;
  logic [OutCntW-1:0] cursor_position;

  modport source (output valid, ok, out_handle, out_length, read_is_current,
                  entry_count, cursor_position, input ready);
  modport sink   (input valid, ok, out_handle, out_length, read_is_current,
                  entry_count, cursor_position, output ready);
endinterface

// ===== sv/ilc_cell.sv =====
module ilc_cell import ilc_pkg::*; (
  input  logic            clk_i,
  input  logic [IdxW-1:0] idx_i,
  input  cell_cmd_t       cmd_i,
  input  entry_t          prev_i,
  input  entry_t          next_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output entry_t          q_o,
  output entry_t          rd_o
);

  entry_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.pos_idx) begin
        data_d = prev_i;
      end else if (idx_i == cmd_i.pos_idx) begin
        data_d = cmd_i.data;
      end
    end else if (cmd_i.rem && (idx_i >= cmd_i.pos_idx)) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o  = data_q;
  // drives the shared read bus only when addressed
  assign rd_o = (rd_idx_i == idx_i) ? data_q : '0;

endmodule

// ===== sv/indexed_list_with_cursor.sv =====
// Ordered list of up to CAPACITY records with a cursor, held in a row of
// shifting cells.
// in_ch_i carries one command per transaction: opcode, one-based position,
// and the record handle and length for an insert. out_ch_o returns one
// result per command: ok flag, the read entry or the current entry, the
// read-is-current flag, the entry count and the cursor position.
// Each command passes two steps: the state update at the accepting edge,
// then the entry lookup, whose result is registered into the output.
// The next command is taken at the earliest at the edge where its
// predecessor's result is taken, so no command is accepted while the
// previous one is still in the update/lookup pair.
// Reset clears the count and cursor (empty list, no current entry) and
// the handshake state; record cells are not cleared.
// When the receiver stalls the result holds in the output register and
// no further command is accepted until it is taken.
module indexed_list_with_cursor import ilc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ilc_in_if.sink    in_ch_i,
  ilc_out_if.source out_ch_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic            busy_q;
  logic            out_valid_q;
  logic            ok_q, ok_d;
  logic            is_read_q;
  logic            is_cur_q, is_cur_d;
  logic [PosW-1:0] pos_q;
  entry_t          out_data_q;
  logic            out_ok_q, out_cur_q;

  logic            accept;
  cell_cmd_t       cmd;
  logic [CmpW-1:0] pz, cz, kz, pm1;

  assign in_ch_i.ready = !busy_q && (!out_valid_q || out_ch_o.ready);
  assign accept        = in_ch_i.valid && in_ch_i.ready;

  assign pz  = CmpW'(in_ch_i.position);
  assign cz  = CmpW'(count_q);
  assign kz  = CmpW'(cursor_q);
  assign pm1 = pz - CmpW'(1);

  always_comb begin
    count_d     = count_q;
    cursor_d    = cursor_q;
    ok_d        = 1'b0;
    is_cur_d    = 1'b0;
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    cmd.pos_idx = pm1[IdxW-1:0];
    cmd.data    = '{handle: in_ch_i.record_handle, length: in_ch_i.record_length};
    unique case (in_ch_i.opcode)
      OP_INSERT: begin
        if (pz >= CmpW'(1) && pz <= cz + CmpW'(1) && cz < CmpW'(CAPACITY)) begin
          ok_d    = 1'b1;
          cmd.ins = accept;
          count_d = count_q + CntW'(1);
          if (cursor_q == '0) begin
            cursor_d = CntW'(1);
          end else if (kz >= pz) begin
            cursor_d = cursor_q + CntW'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (pz >= CmpW'(1) && pz <= cz) begin
          ok_d    = 1'b1;
          cmd.rem = accept;
          count_d = count_q - CntW'(1);
          if (kz == pz) begin
            // current entry gone: next, else previous, else none
            if (pz < cz) begin
              cursor_d = cursor_q;
            end else if (pz > CmpW'(1)) begin
              cursor_d = cursor_q - CntW'(1);
            end else begin
              cursor_d = '0;
            end
          end else if (kz > pz) begin
            cursor_d = cursor_q - CntW'(1);
          end
        end
      end
      OP_SELECT: begin
        if (pz >= CmpW'(1) && pz <= cz) begin
          ok_d     = 1'b1;
          cursor_d = pz[CntW-1:0];
        end
      end
      OP_NEXT: begin
        if (cursor_q != '0 && cursor_q < count_q) begin
          ok_d     = 1'b1;
          cursor_d = cursor_q + CntW'(1);
        end
      end
      OP_PREV: begin
        if (cursor_q > CntW'(1)) begin
          ok_d     = 1'b1;
          cursor_d = cursor_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (pz >= CmpW'(1) && pz <= cz) begin
          ok_d     = 1'b1;
          is_cur_d = (kz == pz);
        end
      end
      default: ;
    endcase
  end

  // cell row
  entry_t          cell_q  [CAPACITY];
  entry_t          cell_rd [CAPACITY];
  logic [CmpW-1:0] rd_pos;
  logic [CmpW-1:0] rd_addr;
  logic            rd_hit;
  entry_t          rd_data;

  assign rd_pos  = is_read_q ? CmpW'(pos_q) : CmpW'(cursor_q);
  assign rd_addr = rd_pos - CmpW'(1);
  assign rd_hit  = is_read_q ? ok_q : (cursor_q != '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilc_cell u_cell (
      .clk_i    (clk_i),
      .idx_i    (IdxW'(i)),
      .cmd_i    (cmd),
      .prev_i   ((i == 0) ? entry_t'('0) : cell_q[(i == 0) ? 0 : i - 1]),
      .next_i   ((i == CAPACITY - 1) ? entry_t'('0)
                                     : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
      .rd_idx_i (rd_addr[IdxW-1:0]),
      .q_o      (cell_q[i]),
      .rd_o     (cell_rd[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
      busy_q <= accept;
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      is_cur_q  <= is_cur_d;
      is_read_q <= (in_ch_i.opcode == OP_READ);
      pos_q     <= in_ch_i.position;
    end
    if (busy_q) begin
      out_data_q <= rd_hit ? rd_data : '0;
      out_ok_q   <= ok_q;
      out_cur_q  <= is_cur_q;
    end
  end

  assign out_ch_o.valid           = out_valid_q;
  assign out_ch_o.ok              = out_ok_q;
  assign out_ch_o.out_handle      = out_data_q.handle;
  assign out_ch_o.out_length      = out_data_q.length;
  assign out_ch_o.read_is_current = out_cur_q;
  assign out_ch_o.entry_count     = OutCntW'(count_q);
  assign out_ch_o.cursor_position = OutCntW'(cursor_q);

endmodule
